// ----- design/xoshiro256plus_byte_source_unit_macros.svh -----
// Assertion macros used by the checker file.
`ifndef XOSHIRO256PLUS_BYTE_SOURCE_UNIT_MACROS_SVH
`define XOSHIRO256PLUS_BYTE_SOURCE_UNIT_MACROS_SVH

// Checked only outside reset.
`define XBS_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define XBS_CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/xbs_pkg.sv -----
// Shared types and constants for the xoshiro256+ byte source.
`default_nettype none

package xbs_pkg;

  localparam int WORD_W      = 64;
  localparam int BYTE_W      = 8;
  localparam int COUNT_W     = 4;
  localparam int POS_W       = 4;
  localparam int NUM_SEEDS   = 4;
  localparam int SEED_IDX_W  = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int SHIFT_AMT   = 17;
  localparam int ROTATE_AMT  = 45;

  localparam logic [COUNT_W-1:0] WORD_BYTES = COUNT_W'(8);
  localparam logic [POS_W-1:0]   POS_EMPTY  = POS_W'(8);

  // Controller to datapath command.
  typedef struct packed {
    logic emit;   // load next byte into the output register
    logic last;   // that byte closes the request
  } ctrl_cmd_t;

endpackage

`default_nettype wire

// ----- design/xbs_ctrl.sv -----
// Request controller: accepts counts, sequences byte transfers, owns out valid.
`default_nettype none

module xbs_ctrl
  import xbs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [COUNT_W-1:0] req_count,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output ctrl_cmd_t               cmd
);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_SERVE = 1'b1;

  logic               state_r, state_nxt;
  logic [COUNT_W-1:0] rem_r, rem_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] clamped;
  logic               slot_free;

  assign clamped   = (req_count > WORD_BYTES) ? WORD_BYTES : req_count;
  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  assign cmd.emit = (state_r == S_SERVE) && slot_free;
  assign cmd.last = (rem_r == COUNT_W'(1));

  always_comb begin
    state_nxt     = state_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        // zero count: taken, nothing produced
        if (in_tvalid && (clamped != '0)) begin
          state_nxt = S_SERVE;
          rem_nxt   = clamped;
        end
      end
      S_SERVE: begin
        if (cmd.emit) begin
          out_valid_nxt = 1'b1;
          rem_nxt       = rem_r - COUNT_W'(1);
          if (cmd.last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/xbs_dp.sv -----
// Datapath: seed registers, generator state, current word and output register.
`default_nettype none

module xbs_dp
  import xbs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_data,
  input  wire ctrl_cmd_t            cmd,
  output logic [BYTE_W-1:0]         out_byte,
  output logic                      out_last
);

  logic [WORD_W-1:0] seed_r [NUM_SEEDS];
  logic [WORD_W-1:0] seed_nxt [NUM_SEEDS];
  logic [WORD_W-1:0] gen_r [NUM_SEEDS];
  logic [WORD_W-1:0] gen_nxt [NUM_SEEDS];
  logic [WORD_W-1:0] cur_r, cur_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic              last_r, last_nxt;

  logic              seed_hit;
  logic [WORD_W-1:0] sum;
  logic [WORD_W-1:0] t2, t3, s0, s1, s2, s3;

  assign seed_hit = cfg_we && (cfg_index < CFG_IDX_W'(NUM_SEEDS));

  // One xoshiro256+ step.
  always_comb begin
    sum = gen_r[0] + gen_r[3];
    t2  = gen_r[2] ^ gen_r[0];
    t3  = gen_r[3] ^ gen_r[1];
    s1  = gen_r[1] ^ t2;
    s0  = gen_r[0] ^ t3;
    s2  = t2 ^ (gen_r[1] << SHIFT_AMT);
    s3  = (t3 << ROTATE_AMT) | (t3 >> (WORD_W - ROTATE_AMT));
  end

  always_comb begin
    seed_nxt = seed_r;
    gen_nxt  = gen_r;
    cur_nxt  = cur_r;
    pos_nxt  = pos_r;
    byte_nxt = byte_r;
    last_nxt = last_r;
    if (seed_hit) begin
      seed_nxt[cfg_index[SEED_IDX_W-1:0]] = cfg_data;
      gen_nxt = seed_nxt;
      cur_nxt = '0;
      pos_nxt = POS_EMPTY;
    end else if (cmd.emit) begin
      last_nxt = cmd.last;
      if (pos_r[POS_W-1]) begin
        // word used up (or bad position): draw a fresh one
        gen_nxt[0] = s0;
        gen_nxt[1] = s1;
        gen_nxt[2] = s2;
        gen_nxt[3] = s3;
        cur_nxt    = sum;
        byte_nxt   = sum[BYTE_W-1:0];
        pos_nxt    = POS_W'(1);
      end else begin
        byte_nxt = cur_r[pos_r[POS_W-2:0]*BYTE_W +: BYTE_W];
        pos_nxt  = pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SEEDS; i++) begin
        seed_r[i] <= WORD_W'(i + 1);
        gen_r[i]  <= WORD_W'(i + 1);
      end
      cur_r <= '0;
      pos_r <= POS_EMPTY;
    end else begin
      seed_r <= seed_nxt;
      gen_r  <= gen_nxt;
      cur_r  <= cur_nxt;
      pos_r  <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  assign out_byte = byte_r;
  assign out_last = last_r;

endmodule

`default_nettype wire

// ----- design/xoshiro256plus_byte_source_unit.sv -----
// Top level of the xoshiro256+ byte source.
//
// Usage:
//  - in_*: one transfer is a request; in_tdata[3:0] holds byte_count (1..8).
//    A count of 0 is taken and yields nothing; 9..15 is served as 8.
//  - out_*: one transfer per random byte, low byte of each 64-bit word first.
//    out_tlast marks the final byte of the request.
//  - cfg_*: cfg_we writes cfg_data into seed register cfg_index (0..3);
//    other indexes are ignored. Any seed write reloads all four state words
//    and drops the partly used word. Write only while the block is idle.
// Timing:
//  - A request is taken while idle; its N bytes then load the output
//    register one per cycle unless the receiver stalls. The first byte
//    shows once the serve state and then the byte are registered. The
//    generator step (one 64-bit add plus xor/shift/rotate) runs in the
//    same cycle as the byte load, so word boundaries cost nothing.
//  - in_tready is high only between requests; the next request can be taken
//    while the last byte of the previous one still waits in the output
//    register.
// Reset: seeds 1,2,3,4 loaded into the state, current word empty, no
//  output pending. When the receiver stalls, the output register holds its
//  byte and byte generation pauses.
`default_nettype none

module xoshiro256plus_byte_source_unit
  import xbs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_data,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [7:0]           in_tdata,   // [3:0] byte_count, [7:4] zero
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [7:0]                out_tdata,  // [7:0] data_byte
  output logic                      out_tlast   // last_byte
);

  ctrl_cmd_t cmd;

  xbs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .req_count  (in_tdata[COUNT_W-1:0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  xbs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .out_byte  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

`default_nettype wire

// ----- design/xbs_checker.sv -----
// Port-level checker for the byte source, bound to the top level.
`default_nettype none
`include "xoshiro256plus_byte_source_unit_macros.svh"

module xbs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [7:0]  in_tdata,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [7:0]  out_tdata,
  input wire logic        out_tlast
);

  `XBS_CHECK(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled output changed")
  `XBS_CHECK_ALWAYS(a_reset_quiet, !rst_n |=> !out_tvalid, "output valid right after reset")
  `XBS_CHECK(a_busy_after_req, in_tvalid && in_tready && (in_tdata[3:0] != 4'd0) |=> !in_tready, "request taken while serving")
  `XBS_CHECK(a_mid_request, out_tvalid && out_tready && !out_tlast |-> !in_tready, "ready high inside a request")

endmodule

bind xoshiro256plus_byte_source_unit xbs_checker u_xbs_checker (.*);

`default_nettype wire
